/* src/raw_group_window_scheduler_top_macros.svh */
// Assertion macros shared by the scheduler modules.
`ifndef RAW_GROUP_WINDOW_SCHEDULER_TOP_MACROS_SVH
`define RAW_GROUP_WINDOW_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RGWS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rgws assertion failed");
// Next-cycle implication, checked outside reset.
`define RGWS_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rgws assertion failed");
`else
`define RGWS_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RGWS_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

/* src/rgws_pkg.sv */
// Shared types, widths and constants of the window scheduler.
package rgws_pkg;

  localparam int unsigned CfgWidth            = 11;
  localparam int unsigned CfgIdxWidth         = 2;
  localparam int unsigned AidWidth            = 13;
  localparam int unsigned QlenWidth           = 12;
  localparam int unsigned KindWidth           = 3;
  localparam int unsigned WordWidth           = 24;
  localparam int unsigned ThrWidth            = 10;
  localparam int unsigned AidFieldBitsDefault = 11;
  localparam int unsigned ProdWidth           = 2 * CfgWidth;
  localparam int unsigned SpanWidth           = ProdWidth + 1;
  localparam int unsigned EndShift            = 13;
  localparam int unsigned StartShift          = 2;
  localparam int unsigned DivSteps            = AidWidth;

  localparam logic [CfgWidth-1:0]  GroupSizeReset = 11'd50;
  localparam logic [CfgWidth-1:0]  TotalReset     = 11'd100;
  localparam logic [ThrWidth-1:0]  ThrStep        = 10'd50;
  localparam logic [ThrWidth-1:0]  ThrRiseLimit   = 10'd950;
  localparam logic [ThrWidth-1:0]  ThrFloor       = 10'd50;
  localparam logic [ThrWidth-1:0]  ThrMax         = 10'd1000;
  localparam logic [QlenWidth-1:0] QlenLowMark    = 12'd10;

  typedef enum logic [0:0] {
    OP_BEACON = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_GROUP_SIZE     = 2'd0,
    CFG_TOTAL_STATIONS = 2'd1
  } cfg_index_e;

  typedef enum logic [KindWidth-1:0] {
    KIND_BEACON      = 3'd0,
    KIND_FORWARD     = 3'd1,
    KIND_DEFERRED    = 3'd2,
    KIND_DROPPED     = 3'd3,
    KIND_UNREACHABLE = 3'd4
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic load_prod;
    logic div_start;
    logic div_second;
    logic cap_first;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

/* src/rgws_divider.sv */
// Restoring divider that retires one quotient bit per cycle.
module rgws_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rgws_pkg::AidWidth-1:0] dividend_i,
  input  logic [rgws_pkg::CfgWidth-1:0] divisor_i,
  output logic                          done_o,
  output logic [rgws_pkg::AidWidth-1:0] quot_o,
  output logic [rgws_pkg::CfgWidth-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(rgws_pkg::DivSteps + 1);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(rgws_pkg::DivSteps - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntWidth-1:0]           cnt_q, cnt_d;
  logic [rgws_pkg::AidWidth-1:0] quot_q;
  logic [rgws_pkg::CfgWidth-1:0] rem_q;
  logic [rgws_pkg::CfgWidth-1:0] divisor_q;
  logic [rgws_pkg::CfgWidth:0]   rem_shift;
  logic [rgws_pkg::CfgWidth:0]   diff;
  logic                          fits;

  assign rem_shift = {rem_q, quot_q[rgws_pkg::AidWidth-1]};
  assign fits      = rem_shift >= {1'b0, divisor_q};
  assign diff      = rem_shift - {1'b0, divisor_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[rgws_pkg::AidWidth-2:0], fits};
      rem_q  <= fits ? diff[rgws_pkg::CfgWidth-1:0] : rem_shift[rgws_pkg::CfgWidth-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* src/rgws_ctrl.sv */
// Sequencer that steps one item through product, two divisions and commit.
`include "raw_group_window_scheduler_top_macros.svh"

module rgws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  rgws_pkg::dp_status_t status_i,
  output rgws_pkg::ctrl_cmd_t  cmd_o
);

  rgws_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rgws_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rgws_pkg::ST_PROD;
      end
      rgws_pkg::ST_PROD: begin
        state_d = rgws_pkg::ST_DIV1_WAIT;
      end
      rgws_pkg::ST_DIV1_WAIT: begin
        if (status_i.div_done) state_d = rgws_pkg::ST_DIV2_GO;
      end
      rgws_pkg::ST_DIV2_GO: begin
        state_d = rgws_pkg::ST_DIV2_WAIT;
      end
      rgws_pkg::ST_DIV2_WAIT: begin
        if (status_i.div_done) state_d = rgws_pkg::ST_FINISH;
      end
      rgws_pkg::ST_FINISH: begin
        if (slot_free) state_d = rgws_pkg::ST_IDLE;
      end
      default: begin
        state_d = rgws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rgws_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      rgws_pkg::ST_PROD: begin
        cmd_o.load_prod = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      rgws_pkg::ST_DIV1_WAIT: begin
        cmd_o.cap_first = status_i.div_done;
      end
      rgws_pkg::ST_DIV2_GO: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_second = 1'b1;
      end
      rgws_pkg::ST_DIV2_WAIT: begin
        cmd_o.div_second = 1'b1;
      end
      rgws_pkg::ST_FINISH: begin
        cmd_o.commit = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgws_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RGWS_ASSERT_IMP(a_commit_slot_free, clk_i, rst_ni, cmd_o.commit, slot_free)
  `RGWS_ASSERT_NXT(a_accept_blocks_input, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RGWS_ASSERT_IMP(a_done_only_waiting, clk_i, rst_ni, status_i.div_done, state_q == rgws_pkg::ST_DIV1_WAIT || state_q == rgws_pkg::ST_DIV2_WAIT)

endmodule

/* src/rgws_datapath.sv */
// Registers, window arithmetic and result selection of the scheduler.
`include "raw_group_window_scheduler_top_macros.svh"

module rgws_datapath #(
  parameter int unsigned AidFieldBits = rgws_pkg::AidFieldBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rgws_pkg::ctrl_cmd_t              cmd_i,
  output rgws_pkg::dp_status_t             status_o,
  input  logic                             cfg_valid_i,
  input  logic [rgws_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [rgws_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                             opcode_i,
  input  logic [rgws_pkg::AidWidth-1:0]    station_aid_i,
  input  logic                             station_associated_i,
  input  logic [rgws_pkg::QlenWidth-1:0]   mgmt_queue_len_i,
  output logic [rgws_pkg::KindWidth-1:0]   result_kind_o,
  output logic [rgws_pkg::WordWidth-1:0]   raw_group_word_o,
  output logic [rgws_pkg::ThrWidth-1:0]    auth_threshold_o,
  output logic                             dtim_beacon_o,
  output logic [rgws_pkg::CfgWidth-1:0]    wait_beacons_o
);

  localparam int unsigned CW = rgws_pkg::CfgWidth;
  localparam int unsigned AW = rgws_pkg::AidWidth;
  localparam int unsigned SW = rgws_pkg::SpanWidth;
  localparam int unsigned PackWidth = rgws_pkg::EndShift + SW;
  localparam logic [SW-1:0] FieldMask = SW'((1 << AidFieldBits) - 1);

  // Configuration and architectural state.
  logic [CW-1:0]                 group_size_q, total_q;
  logic [CW-1:0]                 window_q, window_d;
  logic [rgws_pkg::ThrWidth-1:0] thr_q, thr_d;
  logic [CW-1:0]                 tim_q;

  // Latched item and intermediate results.
  rgws_pkg::opcode_e              op_q;
  logic [AW-1:0]                  aid_q;
  logic                           assoc_q;
  logic [rgws_pkg::QlenWidth-1:0] qlen_q;
  logic [rgws_pkg::ProdWidth-1:0] prod_q;
  logic [AW-1:0]                  q1_q;
  logic                           r1nz_q;

  // Result register.
  rgws_pkg::result_kind_e        kind_q, kind_d;
  logic [rgws_pkg::WordWidth-1:0] word_q, word_d;
  logic [rgws_pkg::ThrWidth-1:0] thr_out_q, thr_out_d;
  logic                          dtim_q, dtim_d;
  logic [CW-1:0]                 wait_q, wait_d;

  logic [CW-1:0]   g;
  logic [AW-1:0]   div_dividend;
  logic [CW-1:0]   div_divisor;
  logic            div_done;
  logic [AW-1:0]   div_quot;
  logic [CW-1:0]   div_rem;
  logic [CW:0]     ceil_w;
  logic [CW-1:0]   ntim;
  logic [SW-1:0]   start_w, end_w, adv_w, aid_w;
  logic [PackWidth-1:0] pack_w;
  logic [CW-1:0]   m_cnt, j_lo, base_w;
  logic            in_window, unreach;

  assign g = (group_size_q == '0) ? CW'(1) : group_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= rgws_pkg::GroupSizeReset;
      total_q      <= rgws_pkg::TotalReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rgws_pkg::CFG_GROUP_SIZE:     group_size_q <= cfg_data_i;
        rgws_pkg::CFG_TOTAL_STATIONS: total_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= rgws_pkg::opcode_e'(opcode_i);
      aid_q   <= station_aid_i;
      assoc_q <= station_associated_i;
      qlen_q  <= mgmt_queue_len_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= rgws_pkg::ProdWidth'(window_q) * rgws_pkg::ProdWidth'(g);
    end
    if (cmd_i.cap_first) begin
      q1_q   <= div_quot;
      r1nz_q <= div_rem != '0;
    end
  end

  // The beacon's group count is the rounded-up quotient of the first pass.
  assign ceil_w = {1'b0, q1_q[CW-1:0]} + (CW+1)'(r1nz_q);
  assign ntim   = (ceil_w == '0) ? CW'(1) : ceil_w[CW-1:0];

  always_comb begin
    if (op_q == rgws_pkg::OP_BEACON) begin
      div_dividend = cmd_i.div_second ? (AW'(tim_q) + AW'(1)) : AW'(total_q);
      div_divisor  = cmd_i.div_second ? ntim : g;
    end else begin
      div_dividend = cmd_i.div_second ? AW'(total_q) : (aid_q - AW'(1));
      div_divisor  = g;
    end
  end

  rgws_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign status_o.div_done = div_done;

  // Window bounds of the current index.
  assign start_w = SW'(prod_q) + SW'(1);
  assign end_w   = SW'(prod_q) + SW'(g);
  assign adv_w   = end_w + SW'(g);
  assign pack_w  = (PackWidth'(end_w & FieldMask) << rgws_pkg::EndShift)
                 | (PackWidth'(start_w & FieldMask) << rgws_pkg::StartShift);

  always_comb begin
    thr_d = thr_q;
    if (qlen_q < rgws_pkg::QlenLowMark) begin
      if (thr_q <= rgws_pkg::ThrRiseLimit) thr_d = thr_q + rgws_pkg::ThrStep;
    end else if (thr_q > rgws_pkg::ThrFloor) begin
      thr_d = thr_q - rgws_pkg::ThrStep;
    end
  end

  assign window_d = (adv_w <= SW'(total_q)) ? (window_q + CW'(1)) : '0;

  // Query path: the second pass gives the rotation length.
  assign aid_w     = SW'(aid_q);
  assign in_window = (aid_w >= start_w) && (aid_w <= end_w);
  assign m_cnt     = (div_quot[CW-1:0] == '0) ? CW'(1) : div_quot[CW-1:0];
  assign unreach   = (aid_q == '0) || (q1_q >= AW'(m_cnt));
  assign j_lo      = q1_q[CW-1:0];
  assign base_w    = (({1'b0, window_q} + (CW+1)'(1)) < {1'b0, m_cnt}) ?
                     (m_cnt - window_q) : CW'(1);

  always_comb begin
    kind_d    = rgws_pkg::KIND_BEACON;
    word_d    = '0;
    thr_out_d = '0;
    dtim_d    = 1'b0;
    wait_d    = '0;
    if (op_q == rgws_pkg::OP_BEACON) begin
      word_d    = pack_w[rgws_pkg::WordWidth-1:0];
      thr_out_d = thr_d;
      dtim_d    = tim_q == '0;
    end else if (!assoc_q) begin
      kind_d = rgws_pkg::KIND_DROPPED;
    end else if (in_window) begin
      kind_d = rgws_pkg::KIND_FORWARD;
    end else if (unreach) begin
      kind_d = rgws_pkg::KIND_UNREACHABLE;
    end else begin
      kind_d = rgws_pkg::KIND_DEFERRED;
      wait_d = (j_lo > window_q) ? (j_lo - window_q) : (base_w + j_lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      thr_q    <= '0;
      tim_q    <= '0;
    end else if (cmd_i.commit && op_q == rgws_pkg::OP_BEACON) begin
      window_q <= window_d;
      thr_q    <= thr_d;
      tim_q    <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      kind_q    <= kind_d;
      word_q    <= word_d;
      thr_out_q <= thr_out_d;
      dtim_q    <= dtim_d;
      wait_q    <= wait_d;
    end
  end

  assign result_kind_o    = kind_q;
  assign raw_group_word_o = word_q;
  assign auth_threshold_o = thr_out_q;
  assign dtim_beacon_o    = dtim_q;
  assign wait_beacons_o   = wait_q;

  `RGWS_ASSERT_IMP(a_tim_below_count, clk_i, rst_ni, cmd_i.commit && op_q == rgws_pkg::OP_BEACON, div_rem < ntim)
  `RGWS_ASSERT_NXT(a_query_keeps_window, clk_i, rst_ni, cmd_i.commit && op_q == rgws_pkg::OP_QUERY, $stable(window_q) && $stable(tim_q))
  `RGWS_ASSERT_IMP(a_thr_bounded, clk_i, rst_ni, 1'b1, thr_q <= rgws_pkg::ThrMax)

endmodule

/* src/raw_group_window_scheduler_top.sv */
// Top level of the restricted-access-window scheduler.
//
// Each input beat is either a beacon tick or a downlink query and yields
// exactly one result beat. The next item is accepted only after the current
// one has been committed to the output register. The processing time is set
// by the shared restoring divider, which retires one quotient bit per cycle
// over 13 steps and is used twice per item: a beacon first divides the
// station total by the group size and then takes the group counter plus one
// modulo the rounded-up count; a query divides its association ID (minus one)
// by the group size and then the station total by the group size.
// A finished result waits in the output register while the next item is
// already accepted and processed; the block only holds at its final step
// when the previous result is still untaken.
// Configuration writes are always ready and take effect at once; they are
// meant to be issued while no item is in flight. Register index 0 is the
// group size and index 1 the station total; other indexes are ignored.
module raw_group_window_scheduler_top #(
  parameter int unsigned AidFieldBits = rgws_pkg::AidFieldBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Item channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [rgws_pkg::AidWidth-1:0]    station_aid_i,
  input  logic                             station_associated_i,
  input  logic [rgws_pkg::QlenWidth-1:0]   mgmt_queue_len_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rgws_pkg::KindWidth-1:0]   result_kind_o,
  output logic [rgws_pkg::WordWidth-1:0]   raw_group_word_o,
  output logic [rgws_pkg::ThrWidth-1:0]    auth_threshold_o,
  output logic                             dtim_beacon_o,
  output logic [rgws_pkg::CfgWidth-1:0]    wait_beacons_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rgws_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [rgws_pkg::CfgWidth-1:0]    cfg_data_i
);

  rgws_pkg::ctrl_cmd_t  cmd;
  rgws_pkg::dp_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  // The controller owns the handshakes and sequences the datapath.
  rgws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the window state, the divider and the result register.
  rgws_datapath #(
    .AidFieldBits (AidFieldBits)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .opcode_i             (opcode_i),
    .station_aid_i        (station_aid_i),
    .station_associated_i (station_associated_i),
    .mgmt_queue_len_i     (mgmt_queue_len_i),
    .result_kind_o        (result_kind_o),
    .raw_group_word_o     (raw_group_word_o),
    .auth_threshold_o     (auth_threshold_o),
    .dtim_beacon_o        (dtim_beacon_o),
    .wait_beacons_o       (wait_beacons_o)
  );

endmodule

/* dv/raw_group_window_scheduler_top_test.sv */
// Self-checking testbench for the window scheduler: directed cases, then random traffic.
module raw_group_window_scheduler_top_test;
  import rgws_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 125;
  localparam int unsigned AidMax      = (1 << AidWidth) - 1;
  localparam int unsigned QlenMax     = (1 << QlenWidth) - 1;
  localparam int unsigned FieldMask   = (1 << AidFieldBitsDefault) - 1;
  localparam int unsigned WindowMask  = (1 << CfgWidth) - 1;

  typedef struct packed {
    result_kind_e            kind;
    logic [WordWidth-1:0]    word;
    logic [ThrWidth-1:0]     thr;
    logic                    dtim;
    logic [CfgWidth-1:0]     beacons_to_wait;
  } sched_answer_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic                   opcode      = OP_BEACON;
  logic [AidWidth-1:0]    station_aid = '0;
  logic                   station_assoc = 1'b0;
  logic [QlenWidth-1:0]   mgmt_qlen   = '0;

  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [KindWidth-1:0]   result_kind;
  logic [WordWidth-1:0]   raw_group_word;
  logic [ThrWidth-1:0]    auth_threshold;
  logic                   dtim_beacon;
  logic [CfgWidth-1:0]    wait_beacons;

  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index   = CFG_GROUP_SIZE;
  logic [CfgWidth-1:0]    cfg_data    = '0;

  // Shadow copy of the registers and the scheduler state.
  int unsigned grp_size_q  = GroupSizeReset;
  int unsigned sta_total_q = TotalReset;
  int unsigned win_idx_q   = 0;
  int unsigned auth_thr_q  = 0;
  int unsigned tim_ctr_q   = 0;

  sched_answer_t pending_answers[$];

  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned kind_seen[5] = '{0, 0, 0, 0, 0};
  int unsigned idle_cycles = 0;

  // Traffic shaping knobs, set per phase by the tests.
  bit          sender_bursty = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned rx_mode       = 0;
  int unsigned stall_left    = 0;

  logic [CfgWidth-1:0] phase_group [NumPhases] = '{50, 1, 1, 2047, 0, 3, 7, 13};
  logic [CfgWidth-1:0] phase_total [NumPhases] = '{100, 1, 2047, 1, 7, 10, 100, 200};
  int unsigned         phase_low_q [NumPhases] = '{50, 90, 90, 10, 70, 20, 95, 40};

  raw_group_window_scheduler_top u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .station_aid_i       (station_aid),
    .station_associated_i(station_assoc),
    .mgmt_queue_len_i    (mgmt_qlen),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .result_kind_o       (result_kind),
    .raw_group_word_o    (raw_group_word),
    .auth_threshold_o    (auth_threshold),
    .dtim_beacon_o       (dtim_beacon),
    .wait_beacons_o      (wait_beacons),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Computes the answer to one accepted beat and advances the shadow state.
  function automatic sched_answer_t schedule_answer(opcode_e op, logic [AidWidth-1:0] aid,
                                                    logic assoc, logic [QlenWidth-1:0] qlen);
    sched_answer_t ans;
    int unsigned   g;
    int unsigned   k;
    int unsigned   first_aid;
    int unsigned   last_aid;
    int unsigned   ntim;
    int unsigned   nwin;
    int unsigned   aid_grp;
    int unsigned   delay;
    ans       = '0;
    ans.kind  = KIND_BEACON;
    g         = (grp_size_q == 0) ? 1 : grp_size_q;
    k         = win_idx_q;
    first_aid = k * g + 1;
    last_aid  = (k + 1) * g;
    if (op == OP_BEACON) begin
      ans.word = WordWidth'(((last_aid & FieldMask) << EndShift)
                            | ((first_aid & FieldMask) << StartShift));
      if (qlen < QlenLowMark) begin
        if (auth_thr_q <= ThrRiseLimit) auth_thr_q += ThrStep;
      end else if (auth_thr_q > ThrFloor) begin
        auth_thr_q -= ThrStep;
      end
      ans.thr  = ThrWidth'(auth_thr_q);
      ans.dtim = (tim_ctr_q == 0);
      ntim = (sta_total_q + g - 1) / g;
      if (ntim == 0) ntim = 1;
      tim_ctr_q = ((tim_ctr_q + 1) % ntim) & WindowMask;
      // The window wraps to the first group once the next one would overrun the total.
      win_idx_q = ((k + 2) * g <= sta_total_q) ? ((k + 1) & WindowMask) : 0;
    end else if (!assoc) begin
      ans.kind = KIND_DROPPED;
    end else if (aid >= first_aid && aid <= last_aid) begin
      ans.kind = KIND_FORWARD;
    end else begin
      nwin = sta_total_q / g;
      if (nwin == 0) nwin = 1;
      aid_grp = (aid == 0) ? 0 : (aid - 1) / g;
      if (aid == 0 || aid_grp >= nwin) begin
        ans.kind = KIND_UNREACHABLE;
      end else begin
        ans.kind = KIND_DEFERRED;
        if (aid_grp > k) delay = aid_grp - k;
        else delay = ((k + 1 < nwin) ? (nwin - k) : 1) + aid_grp;
        ans.beacons_to_wait = delay[CfgWidth-1:0];
      end
    end
    return ans;
  endfunction

  // Offers one input beat; valid stays up after acceptance so back-to-back beats
  // never lower and raise it in the same step.
  task automatic offer_frame_event(opcode_e op, int unsigned aid, logic assoc,
                                   int unsigned qlen);
    int unsigned          gap;
    logic [AidWidth-1:0]  aid_bits;
    logic [QlenWidth-1:0] qlen_bits;
    gap       = 0;
    aid_bits  = AidWidth'(aid);
    qlen_bits = QlenWidth'(qlen);
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 20);
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    station_aid   <= aid_bits;
    station_assoc <= assoc;
    mgmt_qlen     <= qlen_bits;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(schedule_answer(op, aid_bits, assoc, qlen_bits));
    items_sent++;
  endtask

  // Lowers valid and waits until every answer is back and the block is idle again.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ready);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_e idx, int unsigned value);
    logic [CfgWidth-1:0] value_bits;
    value_bits = CfgWidth'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value_bits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GROUP_SIZE) grp_size_q = value_bits;
    else sta_total_q = value_bits;
    @(posedge clk);
  endtask

  task automatic check_answer_beat();
    sched_answer_t got;
    sched_answer_t want;
    got.kind            = result_kind_e'(result_kind);
    got.word            = raw_group_word;
    got.thr             = auth_threshold;
    got.dtim            = dtim_beacon;
    got.beacons_to_wait = wait_beacons;
    if (result_kind <= KIND_UNREACHABLE) kind_seen[result_kind]++;
    if (pending_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Result beat arrived with nothing pending: kind %0d", got.kind);
      return;
    end
    want = pending_answers.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch (exp/got): kind %0d/%0d word %h/%h thr %0d/%0d dtim %0d/%0d wait %0d/%0d",
                 want.kind, got.kind, want.word, got.word, want.thr, got.thr,
                 want.dtim, got.dtim, want.beacons_to_wait, got.beacons_to_wait);
    end
  endtask

  // Result side: checks each beat taken and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_answer_beat();
      if (rx_mode == 0) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(rx_mode == 1 ? 7 : 1) == 0)
          stall_left = $urandom_range(1, rx_mode == 1 ? 40 : 60);
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no beat moved for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Field extremes and every answer kind, starting from the reset registers.
  task automatic test_directed_cases();
    sender_bursty = 1'b0;
    rx_mode       = 0;
    offer_frame_event(OP_BEACON, 0, 1'b0, 0);               // first beacon is a DTIM beacon
    offer_frame_event(OP_QUERY, 75, 1'b1, 0);               // inside the current window
    offer_frame_event(OP_QUERY, 30, 1'b1, 0);               // earlier window, wraps around
    offer_frame_event(OP_QUERY, AidMax, 1'b0, QlenMax);     // not associated
    offer_frame_event(OP_QUERY, 0, 1'b1, 0);                // ID zero is never served
    offer_frame_event(OP_QUERY, 101, 1'b1, 0);              // beyond the rotation
    offer_frame_event(OP_QUERY, AidMax, 1'b1, 0);
    offer_frame_event(OP_BEACON, 0, 1'b1, QlenLowMark - 1);
    offer_frame_event(OP_QUERY, 100, 1'b1, 0);              // later window, no wrap
    offer_frame_event(OP_BEACON, 0, 1'b0, QlenLowMark);
    offer_frame_event(OP_BEACON, AidMax, 1'b1, QlenMax);    // threshold held at the floor
    offer_frame_event(OP_BEACON, 0, 1'b0, QlenMax);
    settle_block();
    // A group size of zero behaves as one station per window.
    write_register(CFG_GROUP_SIZE, 0);
    write_register(CFG_TOTAL_STATIONS, 5);
    offer_frame_event(OP_BEACON, 0, 1'b0, 0);
    offer_frame_event(OP_QUERY, 5, 1'b1, 0);
    offer_frame_event(OP_QUERY, 6, 1'b1, 0);
    offer_frame_event(OP_BEACON, 0, 1'b0, 0);
    offer_frame_event(OP_QUERY, 1, 1'b1, 0);
    settle_block();
    write_register(CFG_GROUP_SIZE, WindowMask);
    write_register(CFG_TOTAL_STATIONS, WindowMask);
    offer_frame_event(OP_BEACON, 0, 1'b0, 0);
    offer_frame_event(OP_QUERY, WindowMask, 1'b1, 0);
    offer_frame_event(OP_QUERY, WindowMask + 1, 1'b1, 0);
    offer_frame_event(OP_QUERY, 1, 1'b1, 0);
  endtask

  // Random traffic over several register settings, the extremes among them.
  task automatic test_random_phases();
    opcode_e               op;
    int unsigned           aid;
    logic                  assoc;
    int unsigned           qlen;
    int unsigned           g;
    int unsigned           first_aid;
    int unsigned           last_aid;
    int unsigned           pick;
    for (int p = 0; p < NumPhases; p++) begin
      settle_block();
      if (p % 2 == 0) begin
        write_register(CFG_GROUP_SIZE, phase_group[p]);
        write_register(CFG_TOTAL_STATIONS, phase_total[p]);
      end else begin
        write_register(CFG_TOTAL_STATIONS, phase_total[p]);
        write_register(CFG_GROUP_SIZE, phase_group[p]);
      end
      // Phase zero runs with no idling on either side.
      sender_bursty = (p % 3 != 0);
      rx_mode       = p % 3;
      burst_left    = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        op    = ($urandom_range(99) < 40) ? OP_BEACON : OP_QUERY;
        assoc = ($urandom_range(99) < 85);
        qlen  = ($urandom_range(99) < phase_low_q[p]) ? $urandom_range(QlenLowMark - 1)
                                                       : $urandom_range(QlenLowMark, QlenMax);
        g         = (grp_size_q == 0) ? 1 : grp_size_q;
        first_aid = win_idx_q * g + 1;
        last_aid  = (win_idx_q + 1) * g;
        pick      = $urandom_range(99);
        if (pick < 40 && first_aid <= AidMax)
          aid = $urandom_range(first_aid, (last_aid > AidMax) ? AidMax : last_aid);
        else if (pick < 75)
          aid = $urandom_range(1, (sta_total_q + g > AidMax) ? AidMax : sta_total_q + g);
        else if (pick < 85)
          aid = 0;
        else
          aid = $urandom_range(AidMax);
        offer_frame_event(op, aid, assoc, qlen);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_phases();
    settle_block();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d items over %0d register settings plus the directed ones.",
             items_sent, NumPhases);
    $display("Answers: %0d beacon, %0d forward, %0d deferred, %0d dropped, %0d unreachable.",
             kind_seen[KIND_BEACON], kind_seen[KIND_FORWARD], kind_seen[KIND_DEFERRED],
             kind_seen[KIND_DROPPED], kind_seen[KIND_UNREACHABLE]);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d answers never arrived", mismatches, pending_answers.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
